// ===== hdl/pinch_click_gesture_detector_top_macros.svh =====
// ----------------------------------------------------------------------------
// pinch click gesture detector assertion macros
// concurrent checks on clk; PCGD_ASSERT is quiet while rst is high
// ----------------------------------------------------------------------------
`ifndef PINCH_CLICK_GESTURE_DETECTOR_TOP_MACROS_SVH
`define PINCH_CLICK_GESTURE_DETECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PCGD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pcgd check failed");
`define PCGD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("pcgd check failed");
`else
`define PCGD_ASSERT(name, prop)
`define PCGD_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== hdl/pcgd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcgd_pkg
// shared types and constants of the pinch click gesture detector
// ----------------------------------------------------------------------------
package pcgd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;
  localparam int LEVEL_BITS     = 15;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DBL_WINDOW = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_DRAG  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEFER      = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] DBL_WINDOW_RST = 16'd300;
  localparam logic [CFG_DATA_BITS-1:0] HOLD_DRAG_RST  = 16'd300;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_CLICK      = 3'd1,
    EV_DOUBLE     = 3'd2,
    EV_DRAG_START = 3'd3,
    EV_DRAG_END   = 3'd4
  } gesture_t;

  // classification of one frame by the front end
  typedef struct packed {
    logic hand_valid;
    logic near;  // distance below pinch level
    logic far;   // distance above release level
  } frame_flags_t;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] dbl_window;
    logic [CFG_DATA_BITS-1:0] hold_drag;
    logic                     defer;
  } gesture_cfg_t;

endpackage

// ===== hdl/pcgd_front.sv =====
// ----------------------------------------------------------------------------
// pcgd_front
// two-stage distance pipeline: tip deltas, squares, then threshold compare
// ----------------------------------------------------------------------------
module pcgd_front #(
  parameter int COORD_BITS = pcgd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = pcgd_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic                            hand_valid,
  input  logic signed [COORD_BITS-1:0]    thumb_x,
  input  logic signed [COORD_BITS-1:0]    thumb_y,
  input  logic signed [COORD_BITS-1:0]    index_x,
  input  logic signed [COORD_BITS-1:0]    index_y,
  input  logic [pcgd_pkg::LEVEL_BITS-1:0] pinch_level,
  input  logic [pcgd_pkg::LEVEL_BITS-1:0] release_level,
  input  logic [TIME_BITS-1:0]            time_ms,
  output logic [1:0]                      inflight,
  output logic                            push,
  output pcgd_pkg::frame_flags_t          flags,
  output logic [TIME_BITS-1:0]            push_time
);

  localparam int LW   = pcgd_pkg::LEVEL_BITS;
  localparam int SQW  = 2 * COORD_BITS;
  localparam int D2W  = SQW + 1;
  localparam int CMPW = (D2W > 2 * LW) ? D2W : 2 * LW;

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      dx_abs, dy_abs;

  // stage 1
  logic                  v1, hv1;
  logic [COORD_BITS-1:0] dx_mag, dy_mag;
  logic [LW-1:0]         pin1, rel1;
  logic [TIME_BITS-1:0]  t1;

  // stage 2
  logic                  v2, hv2;
  logic [SQW-1:0]        dx2, dy2;
  logic [2*LW-1:0]       pin2, rel2;
  logic [TIME_BITS-1:0]  t2;

  logic [D2W-1:0]        d2;

  always_comb begin
    dx = $signed({thumb_x[COORD_BITS-1], thumb_x}) - $signed({index_x[COORD_BITS-1], index_x});
    dy = $signed({thumb_y[COORD_BITS-1], thumb_y}) - $signed({index_y[COORD_BITS-1], index_y});
    dx_abs = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    dy_abs = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
    end
    hv1    <= hand_valid;
    dx_mag <= dx_abs;
    dy_mag <= dy_abs;
    pin1   <= pinch_level;
    rel1   <= release_level;
    t1     <= time_ms;
    hv2    <= hv1;
    dx2    <= SQW'(dx_mag) * SQW'(dx_mag);
    dy2    <= SQW'(dy_mag) * SQW'(dy_mag);
    pin2   <= (2*LW)'(pin1) * (2*LW)'(pin1);
    rel2   <= (2*LW)'(rel1) * (2*LW)'(rel1);
    t2     <= t1;
  end

  always_comb begin
    d2               = D2W'(dx2) + D2W'(dy2);
    push             = v2;
    flags.hand_valid = hv2;
    flags.near       = CMPW'(d2) < CMPW'(pin2);
    flags.far        = CMPW'(d2) > CMPW'(rel2);
    push_time        = t2;
    inflight         = {1'b0, v1} + {1'b0, v2};
  end

endmodule

// ===== hdl/pcgd_queue.sv =====
// ----------------------------------------------------------------------------
// pcgd_queue
// short queue between the classifying front end and the gesture back end
// ----------------------------------------------------------------------------
`include "pinch_click_gesture_detector_top_macros.svh"

module pcgd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcgd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  assign rdata = slots[rd_ptr];
  assign empty = (count == '0);

  `PCGD_ASSERT(a_no_overflow, push |-> (count < CW'(DEPTH)) || pop)
  `PCGD_ASSERT(a_no_underflow, pop |-> !empty)
  `PCGD_ASSERT(a_count_bound, count <= CW'(DEPTH))

endmodule

// ===== hdl/pcgd_back.sv =====
// ----------------------------------------------------------------------------
// pcgd_back
// gesture phase tracker: clicks, double clicks, drags, deferred clicks
// ----------------------------------------------------------------------------
`include "pinch_click_gesture_detector_top_macros.svh"

module pcgd_back #(
  parameter int TIME_BITS = pcgd_pkg::TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pcgd_pkg::gesture_cfg_t cfg,
  input  logic                   q_empty,
  input  pcgd_pkg::frame_flags_t q_flags,
  input  logic [TIME_BITS-1:0]   q_time,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             gesture_event
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PINCH = 2'd1,
    PH_HELD  = 2'd2
  } phase_t;

  phase_t             phase, phase_next;
  logic [TIME_BITS-1:0] pinch_start_time, last_click_time, pending_start_time;
  logic               last_click_known, click_pending;
  logic               click_pending_next;
  logic               set_pinch_start, set_last_click, set_pending_start, set_known;
  pcgd_pkg::gesture_t ev, ev_next;

  logic [TIME_BITS-1:0] window_t, hold_t;
  logic [TIME_BITS-1:0] pend_age, click_age, pinch_age;
  logic                 pend_fire;

  always_comb begin
    window_t  = TIME_BITS'(cfg.dbl_window);
    hold_t    = TIME_BITS'(cfg.hold_drag);
    pend_age  = q_time - pending_start_time;
    click_age = q_time - last_click_time;
    pinch_age = q_time - pinch_start_time;
    pend_fire = click_pending && (pend_age >= window_t);
  end

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    phase_next         = phase;
    click_pending_next = click_pending;
    ev_next            = pcgd_pkg::EV_NONE;
    set_pinch_start    = 1'b0;
    set_last_click     = 1'b0;
    set_pending_start  = 1'b0;
    set_known          = 1'b0;
    if (q_flags.hand_valid) begin
      if (pend_fire) begin
        click_pending_next = 1'b0;
        ev_next            = pcgd_pkg::EV_CLICK;
      end else begin
        case (phase)
          PH_PINCH: begin
            if (q_flags.far) begin
              if (last_click_known && (click_age < window_t)) begin
                ev_next            = pcgd_pkg::EV_DOUBLE;
                click_pending_next = 1'b0;
              end else if (cfg.defer) begin
                click_pending_next = 1'b1;
                set_pending_start  = 1'b1;
              end else begin
                ev_next = pcgd_pkg::EV_CLICK;
              end
              set_last_click = 1'b1;
              set_known      = 1'b1;
              phase_next     = PH_IDLE;
            end else if (pinch_age > hold_t) begin
              ev_next    = pcgd_pkg::EV_DRAG_START;
              phase_next = PH_HELD;
            end
          end
          PH_HELD: begin
            if (q_flags.far) begin
              ev_next    = pcgd_pkg::EV_DRAG_END;
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            if (q_flags.near) begin
              phase_next      = PH_PINCH;
              set_pinch_start = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      click_pending    <= 1'b0;
      last_click_known <= 1'b0;
      out_valid        <= 1'b0;
      ev               <= pcgd_pkg::EV_NONE;
    end else if (pop) begin
      phase         <= phase_next;
      click_pending <= click_pending_next;
      out_valid     <= 1'b1;
      ev            <= ev_next;
      if (set_known) begin
        last_click_known <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (pop && set_pinch_start) begin
      pinch_start_time <= q_time;
    end
    if (pop && set_last_click) begin
      last_click_time <= q_time;
    end
    if (pop && set_pending_start) begin
      pending_start_time <= q_time;
    end
  end

  assign gesture_event = ev;

  `PCGD_ASSERT(a_no_hand_no_event, (pop && !q_flags.hand_valid) |=> (ev == pcgd_pkg::EV_NONE))
  `PCGD_ASSERT(a_fire_clears_pending, (pop && q_flags.hand_valid && pend_fire) |=> !click_pending)
  `PCGD_ASSERT(a_drag_end_from_held, (pop && ev_next == pcgd_pkg::EV_DRAG_END) |-> (phase == PH_HELD))
  `PCGD_ASSERT(a_pop_gives_beat, pop |=> out_valid)

endmodule

// ===== hdl/pinch_click_gesture_detector_top.sv =====
// ----------------------------------------------------------------------------
// pinch_click_gesture_detector_top
// one gesture event per hand frame from squared tip distance with hysteresis
// ----------------------------------------------------------------------------
// throughput: one frame per cycle unless a stall holds it, set by the back end phase update
// path: an accepted frame passes the delta stage, the square stage and the queue write,
//   then the phase update into the output register, where its event beat is valid
// the front end admits a frame only while the four-entry queue has a slot for it
// rst (synchronous) empties the pipeline and queue, returns to idle with no click
//   pending or known, and loads the register reset values
module pinch_click_gesture_detector_top #(
  parameter int COORD_BITS = pcgd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = pcgd_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               hand_valid,
  input  logic signed [COORD_BITS-1:0]       thumb_x,
  input  logic signed [COORD_BITS-1:0]       thumb_y,
  input  logic signed [COORD_BITS-1:0]       index_x,
  input  logic signed [COORD_BITS-1:0]       index_y,
  input  logic [pcgd_pkg::LEVEL_BITS-1:0]    pinch_level,
  input  logic [pcgd_pkg::LEVEL_BITS-1:0]    release_level,
  input  logic [TIME_BITS-1:0]               time_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         gesture_event,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pcgd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pcgd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int DEPTH = pcgd_pkg::QUEUE_DEPTH;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int QW    = TIME_BITS + $bits(pcgd_pkg::frame_flags_t);
  localparam int SW    = CW + 1;

  pcgd_pkg::gesture_cfg_t cfg;
  pcgd_pkg::frame_flags_t push_flags, q_flags;
  logic [TIME_BITS-1:0]   push_time, q_time;
  logic [1:0]             inflight;
  logic                   take, push, pop, q_empty;
  logic [CW-1:0]          q_count;
  logic [QW-1:0]          q_rdata;

  // credit check: queue entries plus frames still in the front pipeline
  assign in_stall  = (SW'(q_count) + SW'(inflight)) >= SW'(DEPTH);
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dbl_window <= pcgd_pkg::DBL_WINDOW_RST;
      cfg.hold_drag  <= pcgd_pkg::HOLD_DRAG_RST;
      cfg.defer      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcgd_pkg::CFG_DBL_WINDOW: cfg.dbl_window <= cfg_data;
        pcgd_pkg::CFG_HOLD_DRAG:  cfg.hold_drag  <= cfg_data;
        pcgd_pkg::CFG_DEFER:      cfg.defer      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pcgd_front #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .hand_valid   (hand_valid),
    .thumb_x      (thumb_x),
    .thumb_y      (thumb_y),
    .index_x      (index_x),
    .index_y      (index_y),
    .pinch_level  (pinch_level),
    .release_level(release_level),
    .time_ms      (time_ms),
    .inflight     (inflight),
    .push         (push),
    .flags        (push_flags),
    .push_time    (push_time)
  );

  pcgd_queue #(
    .WIDTH(QW),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({push_time, push_flags}),
    .pop  (pop),
    .rdata(q_rdata),
    .empty(q_empty),
    .count(q_count)
  );

  assign q_flags = q_rdata[$bits(pcgd_pkg::frame_flags_t)-1:0];
  assign q_time  = q_rdata[QW-1:$bits(pcgd_pkg::frame_flags_t)];

  pcgd_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_flags      (q_flags),
    .q_time       (q_time),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gesture_event(gesture_event)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pinch click gesture detector: a directed table
// of frames and register writes, then phases of random pinch gestures under
// varied register settings and handshake pressure, every event beat compared
// with the table's expected event or a cycle-free model of the phase tracker
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = pcgd_pkg::COORD_BITS_DEF;
  localparam int TB = pcgd_pkg::TIME_BITS_DEF;
  localparam int LW = pcgd_pkg::LEVEL_BITS;
  localparam int IW = pcgd_pkg::CFG_IDX_BITS;
  localparam int DW = pcgd_pkg::CFG_DATA_BITS;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int NUM_PHASES = 8;
  localparam int MAX_REPORTS = 10;

  // index with no register behind it
  localparam logic [IW-1:0] CFG_NO_REG = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PINCH = 2'd1,
    ST_HELD  = 2'd2
  } hand_phase_t;

  typedef struct packed {
    logic                  hand;
    logic signed [CB-1:0]  tx;
    logic signed [CB-1:0]  ty;
    logic signed [CB-1:0]  ix;
    logic signed [CB-1:0]  iy;
    logic [LW-1:0]         pin;
    logic [LW-1:0]         rel;
    logic [TB-1:0]         t;
  } frame_t;

  localparam int FW = $bits(frame_t);

  typedef struct packed {
    hand_phase_t   ph;
    logic [TB-1:0] pinch_t;
    logic [TB-1:0] click_t;
    logic          click_known;
    logic          pending;
    logic [TB-1:0] pend_t;
  } track_t;

  typedef struct packed {
    logic               is_cfg;
    logic [IW-1:0]      idx;
    logic [DW-1:0]      data;
    frame_t             f;
    logic               typed;
    pcgd_pkg::gesture_t want;
  } step_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic hand_valid;
  logic signed [CB-1:0] thumb_x;
  logic signed [CB-1:0] thumb_y;
  logic signed [CB-1:0] index_x;
  logic signed [CB-1:0] index_y;
  logic [LW-1:0] pinch_level;
  logic [LW-1:0] release_level;
  logic [TB-1:0] time_ms;
  logic out_valid;
  logic out_stall;
  logic [2:0] gesture_event;
  logic cfg_valid;
  logic cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  pinch_click_gesture_detector_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .hand_valid    (hand_valid),
    .thumb_x       (thumb_x),
    .thumb_y       (thumb_y),
    .index_x       (index_x),
    .index_y       (index_y),
    .pinch_level   (pinch_level),
    .release_level (release_level),
    .time_ms       (time_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .gesture_event (gesture_event),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pcgd_pkg::gesture_cfg_t cfg_model;
  track_t                 trk;
  pcgd_pkg::gesture_t     event_q[$];
  step_row_t              steps[$];
  logic [TB-1:0] t_now;
  int error_count;
  int event_count;
  int valid_sent;
  int idle_pct;
  int stall_pct;
  int hold_off_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // phase tracker: one event per frame
  function automatic pcgd_pkg::gesture_t next_gesture(input frame_t f);
    longint dx, dy, d2, p2, r2;
    logic [TB-1:0] el;
    pcgd_pkg::gesture_t ev;
    ev = pcgd_pkg::EV_NONE;
    if (!f.hand) return pcgd_pkg::EV_NONE;
    dx = longint'(f.tx) - longint'(f.ix);
    dy = longint'(f.ty) - longint'(f.iy);
    d2 = dx * dx + dy * dy;
    p2 = longint'(f.pin) * longint'(f.pin);
    r2 = longint'(f.rel) * longint'(f.rel);
    el = f.t - trk.pend_t;
    if (trk.pending && el >= TB'(cfg_model.dbl_window)) begin
      trk.pending = 1'b0;
      return pcgd_pkg::EV_CLICK;
    end
    case (trk.ph)
      ST_PINCH: begin
        el = f.t - trk.pinch_t;
        if (d2 > r2) begin
          if (trk.click_known && (f.t - trk.click_t) < TB'(cfg_model.dbl_window)) begin
            ev = pcgd_pkg::EV_DOUBLE;
            trk.pending = 1'b0;
          end else if (cfg_model.defer) begin
            trk.pending = 1'b1;
            trk.pend_t = f.t;
          end else begin
            ev = pcgd_pkg::EV_CLICK;
          end
          trk.click_t = f.t;
          trk.click_known = 1'b1;
          trk.ph = ST_IDLE;
        end else if (el > TB'(cfg_model.hold_drag)) begin
          ev = pcgd_pkg::EV_DRAG_START;
          trk.ph = ST_HELD;
        end
      end
      ST_HELD: begin
        if (d2 > r2) begin
          ev = pcgd_pkg::EV_DRAG_END;
          trk.ph = ST_IDLE;
        end
      end
      default: begin
        trk.ph = ST_IDLE;
        if (d2 < p2) begin
          trk.ph = ST_PINCH;
          trk.pinch_t = f.t;
        end
      end
    endcase
    return ev;
  endfunction

  task automatic send_frame(input frame_t f, input logic typed,
                            input pcgd_pkg::gesture_t want);
    pcgd_pkg::gesture_t ev;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid      <= 1'b1;
    hand_valid    <= f.hand;
    thumb_x       <= f.tx;
    thumb_y       <= f.ty;
    index_x       <= f.ix;
    index_y       <= f.iy;
    pinch_level   <= f.pin;
    release_level <= f.rel;
    time_ms       <= f.t;
    do @(posedge clk); while (in_stall);
    ev = next_gesture(f);
    event_q.push_back(typed ? want : ev);
    valid_sent++;
  endtask

  // sender pause until every event beat is back
  task automatic drain_events();
    in_valid <= 1'b0;
    do @(posedge clk); while (event_q.size() != 0);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx,
                           input logic [DW-1:0] data);
    drain_events();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pcgd_pkg::CFG_DBL_WINDOW: cfg_model.dbl_window = data;
      pcgd_pkg::CFG_HOLD_DRAG:  cfg_model.hold_drag = data;
      pcgd_pkg::CFG_DEFER:      cfg_model.defer = data[0];
      default: ;
    endcase
  endtask

  task automatic add_frame(input logic hand, input int tx, input int ty, input int ix,
                           input int iy, input int pin, input int rel,
                           input logic [TB-1:0] t, input logic typed,
                           input pcgd_pkg::gesture_t want);
    step_row_t r;
    r = '0;
    r.f = '{hand, CB'(tx), CB'(ty), CB'(ix), CB'(iy), LW'(pin), LW'(rel), t};
    r.typed = typed;
    r.want = want;
    steps.push_back(r);
  endtask

  task automatic add_write(input logic [IW-1:0] idx,
                           input logic [DW-1:0] data);
    step_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    steps.push_back(r);
  endtask

  // kind 0 near, 1 inside the hysteresis band, 2 far
  function automatic frame_t make_frame(input int kind, input int pin, input int rel);
    frame_t f;
    int dx, dy, tx, ty, span, maxw, r;
    maxw = (cfg_model.dbl_window > cfg_model.hold_drag) ?
           int'(cfg_model.dbl_window) : int'(cfg_model.hold_drag);
    span = maxw / 3 + 8;
    r = $urandom_range(0, 29);
    if (r == 0) t_now = $urandom;
    else if (r < 4) t_now = t_now + $urandom_range(0, 2 * maxw + 8);
    else t_now = t_now + $urandom_range(0, span);
    case (kind)
      0: begin
        dx = $urandom_range(0, pin / 2);
        dy = $urandom_range(0, pin / 2);
      end
      1: begin
        dx = pin + $urandom_range(0, (rel > pin) ? rel - pin : 0);
        dy = 0;
      end
      default: begin
        dx = rel + 1 + $urandom_range(0, 3000);
        dy = $urandom_range(0, 1000);
      end
    endcase
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    tx = $urandom_range(0, 24000) - 12000;
    ty = $urandom_range(0, 24000) - 12000;
    f.hand = ($urandom_range(0, 11) != 0);
    f.tx = CB'(tx);
    f.ty = CB'(ty);
    f.ix = CB'(tx + dx);
    f.iy = CB'(ty + dy);
    f.pin = LW'(pin);
    f.rel = LW'(rel);
    f.t = t_now;
    return f;
  endfunction

  // one pinch: a few open frames, a closed stretch, then the release, or at times one random frame instead
  task automatic run_gesture();
    frame_t f;
    int pin, rel, n;
    if ($urandom_range(0, 99) < 15) begin
      f = FW'({$urandom, $urandom, $urandom, $urandom});
      send_frame(f, 1'b0, pcgd_pkg::EV_NONE);
      return;
    end
    pin = $urandom_range(2, 4000);
    rel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4000) :
          pin + $urandom_range(0, 2000);
    n = $urandom_range(0, 2);
    repeat (n) send_frame(make_frame(2, pin, rel), 1'b0, pcgd_pkg::EV_NONE);
    n = $urandom_range(1, 6);
    repeat (n) send_frame(make_frame(($urandom_range(0, 3) == 0) ? 1 : 0, pin, rel),
                          1'b0, pcgd_pkg::EV_NONE);
    n = $urandom_range(1, 2);
    repeat (n) send_frame(make_frame(2, pin, rel), 1'b0, pcgd_pkg::EV_NONE);
  endtask

  // event beats against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (event_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected event beat %0d: got %0d", event_count, gesture_event);
      end else begin
        pcgd_pkg::gesture_t want;
        want = event_q.pop_front();
        if (gesture_event !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("event beat %0d: expected %0d got %0d",
                     event_count, want, gesture_event);
        end
      end
      event_count++;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int wait_cycles;
    logic [DW-1:0] w, h, d;
    rst = 1'b1;
    in_valid = 1'b0;
    hand_valid = 1'b0;
    thumb_x = '0;
    thumb_y = '0;
    index_x = '0;
    index_y = '0;
    pinch_level = '0;
    release_level = '0;
    time_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    event_count = 0;
    valid_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off_left = 0;
    t_now = '0;
    trk = '0;
    cfg_model = '{pcgd_pkg::DBL_WINDOW_RST, pcgd_pkg::HOLD_DRAG_RST, 1'b0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, click, double, drag, threshold edges, wrap, deferral
    add_frame(1'b0, 32767, 32767, 32767, 32767, 32767, 32767, '1, 1'b1,
              pcgd_pkg::EV_NONE);
    add_frame(1'b1, -32768, -32768, 32767, 32767, 32767, 32767, '1, 1'b1,
              pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 0, 0, 1000, 1000, 100, 1'b1, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 2000, 0, 1000, 1000, 150, 1'b1, pcgd_pkg::EV_CLICK);
    add_frame(1'b1, 0, 0, 0, 0, 1000, 1000, 200, 1'b1, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 2000, 0, 1000, 1000, 250, 1'b1, pcgd_pkg::EV_DOUBLE);
    add_frame(1'b1, 0, 0, 0, 0, 1000, 1000, 1000, 1'b1, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 0, 0, 1000, 1000, 1301, 1'b1, pcgd_pkg::EV_DRAG_START);
    add_frame(1'b1, 0, 0, 0, 2000, 1000, 1000, 1500, 1'b1, pcgd_pkg::EV_DRAG_END);
    add_frame(1'b0, 0, 0, 0, 0, 1000, 1000, 1600, 1'b1, pcgd_pkg::EV_NONE);
    // distance exactly at each threshold
    add_frame(1'b1, 0, 0, 1000, 0, 1000, 1000, 2000, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 999, 0, 1000, 1000, 2050, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 1000, 0, 1000, 1000, 2100, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 1001, 0, 1000, 1000, 2200, 1'b0, pcgd_pkg::EV_NONE);
    // timestamp wraps between press and release
    add_frame(1'b1, 100, -100, 100, -100, 500, 900, 32'hFFFF_FF00, 1'b0,
              pcgd_pkg::EV_NONE);
    add_frame(1'b1, 100, -100, -900, -100, 500, 900, 32'h0000_0040, 1'b0,
              pcgd_pkg::EV_NONE);
    add_write(CFG_NO_REG, 16'hFFFF);
    add_write(pcgd_pkg::CFG_DEFER, 16'd1);
    add_frame(1'b1, 0, 0, 0, 0, 1000, 1000, 10000, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 2000, 0, 1000, 1000, 10010, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 0, 0, 1000, 1000, 10200, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 2000, 0, 1000, 1000, 10250, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 0, 0, 1000, 1000, 11000, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 2000, 0, 1000, 1000, 11010, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b0, 0, 0, 2000, 0, 1000, 1000, 20000, 1'b1, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 2000, 0, 1000, 1000, 11310, 1'b0, pcgd_pkg::EV_NONE);
    add_write(pcgd_pkg::CFG_DBL_WINDOW, 16'd0);
    add_frame(1'b1, 0, 0, 0, 0, 1000, 1000, 12000, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 2000, 0, 1000, 1000, 12001, 1'b0, pcgd_pkg::EV_NONE);
    add_frame(1'b1, 0, 0, 2000, 0, 1000, 1000, 12001, 1'b0, pcgd_pkg::EV_NONE);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_reg(steps[i].idx, steps[i].data);
      else send_frame(steps[i].f, steps[i].typed, steps[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin w = 16'd300; h = 16'd300; d = 16'd0; end
        1: begin w = 16'd0; h = 16'd0; d = 16'hFFFF; end
        2: begin w = 16'hFFFF; h = 16'hFFFF; d = 16'd1; end
        3: begin w = 16'd0; h = 16'hFFFF; d = 16'd0; end
        default: begin
          w = DW'($urandom_range(0, 600));
          h = DW'($urandom_range(0, 600));
          d = DW'($urandom_range(0, 65535));
        end
      endcase
      write_reg(pcgd_pkg::CFG_DBL_WINDOW, w);
      write_reg(pcgd_pkg::CFG_HOLD_DRAG, h);
      write_reg(pcgd_pkg::CFG_DEFER, d);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 53; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 53; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      // long receiver hold-off so the queue fills and the input stalls
      if (ph == 0) hold_off_left = 300;
      valid_sent = 0;
      while (valid_sent < ITEMS_PER_PHASE) begin
        run_gesture();
        if ($urandom_range(0, 99) == 0) drain_events();
      end
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (event_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    error_count += event_q.size();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
